// File: sv/pru_pkg.sv
// Shared constants, types and a helper function of the pixel replication upscaler.
package pru_pkg;

   // Sizing of the line buffer and of the upscale factor.
   localparam int MAX_WIDTH = 2048;
   localparam int SCALE_MAX = 64;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = 12;
   localparam int SCALE_W = 7;
   localparam int COPY_W  = $clog2(SCALE_MAX);
   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int PAD_W   = 2;

   // Configuration port sizing.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register indexes, taken from the word address bit of paddr.
   localparam logic REG_SCALE = 1'b0;
   localparam logic REG_WIDTH = 1'b1;

   // Request kinds on the input channel.
   typedef enum logic {
      REQ_PIXEL  = 1'b0,
      REQ_REPLAY = 1'b1
   } req_kind_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [WIDTH_W-1:0] src_width;
      logic               restart;
   } cfg_type;

   // One accepted item on its way to the output replicator.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             at_end;
   } emit_type;

   // Pad byte count of an output row: (src_width * scale) mod 4.
   function automatic logic [PAD_W-1:0] pad_count(logic [WIDTH_W-1:0] width,
                                                  logic [SCALE_W-1:0] scale);
      logic [2*PAD_W-1:0] prod;
      prod = {{PAD_W{1'b0}}, width[PAD_W-1:0]} * {{PAD_W{1'b0}}, scale[PAD_W-1:0]};
      return prod[PAD_W-1:0];
   endfunction

endpackage

// File: sv/pru_req_if.sv
// Input channel of the upscaler: source pixels and replay steps.
interface pru_req_if;
   import pru_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_red;

   modport source(output valid, output req_type, output in_blue, output in_green,
                  output in_red, input ready);
   modport sink(input valid, input req_type, input in_blue, input in_green,
                input in_red, output ready);
endinterface

// File: sv/pru_rsp_if.sv
// Result channel of the upscaler: one output pixel per item.
interface pru_rsp_if;
   import pru_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_red;
   logic [PAD_W-1:0]  pad_bytes;
   logic              row_end;
   logic              last;

   modport source(output valid, output out_blue, output out_green, output out_red,
                  output pad_bytes, output row_end, output last, input ready);
   modport sink(input valid, input out_blue, input out_green, input out_red,
                input pad_bytes, input row_end, input last, output ready);
endinterface

// File: sv/pru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port whose data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pru_csr.sv
// Configuration registers of the upscaler behind an APB-style port.
module pru_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready,
   output pru_pkg::cfg_type                     cfg
);
   import pru_pkg::*;

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic               wr;
   logic               reg_idx;
   logic [SCALE_W-1:0] wr_scale;
   logic [WIDTH_W-1:0] wr_width;
   logic               scale_ok;
   logic               width_ok;
   logic               restart;

   assign wr       = psel && penable && pwrite;
   assign reg_idx  = paddr[2];
   assign wr_scale = pwdata[SCALE_W-1:0];
   assign wr_width = pwdata[WIDTH_W-1:0];
   assign scale_ok = (wr_scale != '0) && (wr_scale <= SCALE_W'(SCALE_MAX));
   assign width_ok = (wr_width != '0) && (wr_width <= WIDTH_W'(MAX_WIDTH));

   // Out-of-range values are dropped; an accepted write restarts the phase.
   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      restart  = 1'b0;
      if (wr) begin
         case (reg_idx)
            REG_SCALE: begin
               if (scale_ok) begin
                  scale_in = wr_scale;
                  restart  = 1'b1;
               end
            end
            REG_WIDTH: begin
               if (width_ok) begin
                  width_in = wr_width;
                  restart  = 1'b1;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(1);
         width_ff <= WIDTH_W'(1);
      end else begin
         scale_ff <= scale_in;
         width_ff <= width_in;
      end
   end

   // Read-back mux.
   always_comb begin
      case (reg_idx)
         REG_SCALE: prdata = CSR_DATA_W'(scale_ff);
         REG_WIDTH: prdata = CSR_DATA_W'(width_ff);
         default:   prdata = '0;
      endcase
   end

   assign pready        = 1'b1;
   assign cfg.scale     = scale_ff;
   assign cfg.src_width = width_ff;
   assign cfg.restart   = restart;

endmodule

// File: sv/pru_emit.sv
// Output replicator: sends each loaded pixel out scale times.
module pru_emit (
   input  logic              clock,
   input  logic              reset,
   input  pru_pkg::cfg_type  cfg,
   input  logic              load_valid,
   input  pru_pkg::emit_type load_item,
   output logic              free,
   pru_rsp_if.source         rsp
);
   import pru_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic               at_end_ff, at_end_in;
   logic [COPY_W-1:0]  cnt_ff, cnt_in;
   logic               final_copy;
   logic [PAD_W-1:0]   pad;

   assign final_copy = ({1'b0, cnt_ff} + SCALE_W'(1)) == cfg.scale;
   assign free       = !out_valid_ff || (rsp.ready && final_copy);
   assign pad        = pad_count(cfg.src_width, cfg.scale);

   // Load a new pixel when the current one has gone out its last time.
   always_comb begin
      out_valid_in = out_valid_ff;
      pix_in       = pix_ff;
      at_end_in    = at_end_ff;
      cnt_in       = cnt_ff;
      if (free) begin
         out_valid_in = load_valid;
         pix_in       = load_item.pixel;
         at_end_in    = load_item.at_end;
         cnt_in       = '0;
      end else if (rsp.ready) begin
         cnt_in = cnt_ff + COPY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
      pix_ff    <= pix_in;
      at_end_ff <= at_end_in;
   end

   // Row end and pad count only ride on the final copy of a row's last pixel.
   assign rsp.valid     = out_valid_ff;
   assign rsp.out_blue  = pix_ff[CHAN_W-1:0];
   assign rsp.out_green = pix_ff[2*CHAN_W-1:CHAN_W];
   assign rsp.out_red   = pix_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp.row_end   = at_end_ff && final_copy;
   assign rsp.pad_bytes = (at_end_ff && final_copy) ? pad : '0;
   assign rsp.last      = final_copy;

endmodule

// File: sv/pixel_replication_upscaler.sv
// Top level of the pixel replication upscaler: phase control, line buffer and output stage.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        req_type, in_blue, in_green, in_red
//   rsp      out        valid/ready        out_blue/green/red, pad_bytes, row_end, last
//   csr      in         APB psel/penable   scale (0x0), src_width (0x4)
//
// An item taken in its phase gives scale results, one per cycle while rsp is ready; at
// scale 1 that is one item per cycle. The output replicator sets the rate. A result is
// registered in the staging register (line buffer read), then in the replicator, which
// drives rsp. Synchronous reset clears phase state and empties both stages; the line
// buffer is not cleared. A stall on rsp holds the replicator and, once the staging
// register is full, drops req.ready. Items of the wrong phase are taken and give no result.
module pixel_replication_upscaler (
   input  logic                            clock,
   input  logic                            reset,
   pru_req_if.sink                         req,
   pru_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import pru_pkg::*;

   cfg_type            cfg;
   logic               accept;
   logic               is_pixel;
   logic               take_pixel;
   logic               take_replay;
   logic               take;
   logic               at_end;
   logic               free;

   logic [COL_W-1:0]   column_ff, column_in;
   logic [COPY_W-1:0]  row_copy_ff, row_copy_in;
   logic               replaying_ff, replaying_in;
   logic [SCALE_W-1:0] copy_next;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_replay_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic               s1_at_end_ff;
   logic [PIX_W-1:0]   rd_pix;
   emit_type           load_item;

   pru_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Phase decode of the incoming item.
   assign req.ready   = !s1_valid_ff || free;
   assign accept      = req.valid && req.ready;
   assign is_pixel    = (req.req_type == REQ_PIXEL);
   assign take_pixel  = accept && is_pixel && !replaying_ff;
   assign take_replay = accept && !is_pixel && replaying_ff;
   assign take        = take_pixel || take_replay;
   assign at_end      = ({1'b0, column_ff} + WIDTH_W'(1)) >= cfg.src_width;
   assign copy_next   = {1'b0, row_copy_ff} + SCALE_W'(1);

   // Line buffer: source pixels are written, replay steps read back.
   pru_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (take_pixel),
      .wr_addr (column_ff),
      .wr_data ({req.in_red, req.in_green, req.in_blue}),
      .rd_en   (take_replay),
      .rd_addr (column_ff),
      .rd_data (rd_pix)
   );

   // Column, row copy and phase bookkeeping.
   always_comb begin
      column_in    = column_ff;
      row_copy_in  = row_copy_ff;
      replaying_in = replaying_ff;
      if (cfg.restart) begin
         column_in    = '0;
         row_copy_in  = '0;
         replaying_in = 1'b0;
      end else if (take) begin
         if (!at_end) begin
            column_in = column_ff + COL_W'(1);
         end else begin
            column_in = '0;
            if (take_pixel) begin
               if (cfg.scale > SCALE_W'(1)) begin
                  replaying_in = 1'b1;
                  row_copy_in  = COPY_W'(1);
               end
            end else if (copy_next >= cfg.scale) begin
               row_copy_in  = '0;
               replaying_in = 1'b0;
            end else begin
               row_copy_in = copy_next[COPY_W-1:0];
            end
         end
      end
   end

   // Staging register between acceptance and the replicator.
   always_comb begin
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_copy_ff  <= '0;
         replaying_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         column_ff    <= column_in;
         row_copy_ff  <= row_copy_in;
         replaying_ff <= replaying_in;
         s1_valid_ff  <= s1_valid_in;
      end
      if (take) begin
         s1_replay_ff <= take_replay;
         s1_pix_ff    <= {req.in_red, req.in_green, req.in_blue};
         s1_at_end_ff <= at_end;
      end
   end

   // Replay items take their pixel from the line buffer read data.
   assign load_item.pixel  = s1_replay_ff ? rd_pix : s1_pix_ff;
   assign load_item.at_end = s1_at_end_ff;

   pru_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load_valid (s1_valid_ff),
      .load_item  (load_item),
      .free       (free),
      .rsp        (rsp)
   );

`ifndef SYNTH
   // Pad bytes appear only on a row end pixel.
   a_pad_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.row_end |-> rsp.pad_bytes == '0)
      else $error("pad bytes outside a row end");

   // A row end is always the final copy of its item.
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.row_end |-> rsp.last)
      else $error("row end on a copy that is not the last");

   // The replay phase exists only for a scale above one.
   a_replay_scale: assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> cfg.scale > SCALE_W'(1))
      else $error("replay phase at scale one");

   // A staged item that cannot move stays staged.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !free |=> s1_valid_ff)
      else $error("staged item lost");
`endif

endmodule
